// File: sv/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

  localparam int SIDE    = 5;
  localparam int CODE_W  = 5;
  localparam int ROW_W   = SIDE * CODE_W;
  localparam int IDX_W   = $clog2(SIDE);
  localparam int CELLS   = SIDE * SIDE;
  localparam int ADDR_W  = $clog2(SIDE);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef row_t square_t [SIDE];

  // configuration register indexes
  localparam addr_t REG_ROW0 = addr_t'(0);
  localparam addr_t REG_ROW4 = addr_t'(SIDE - 1);

  // position of a letter in the square
  typedef struct packed {
    logic hit;   // exactly one cell holds the letter
    idx_t row;
    idx_t col;
  } pos_t;

  function automatic code_t cell_code(input row_t row, input idx_t col);
    cell_code = row[col*CODE_W +: CODE_W];
  endfunction

endpackage
`default_nettype wire

// File: sv/digraph_square_cipher.sv
// Pipeline: an input transfer loads the input register, then the result register, which
// drives out_valid. Throughput: one letter pair per cycle while out_stall is low; the
// lookup is a parallel compare against all 25 cells of the square followed by a cell mux,
// all between the two registers.
// Stalls: in_stall rises only when both registers are full and out_stall is high.
// Reset: synchronous, active low; clears both stage valids and all square rows to 0.
`default_nettype none
module digraph_square_cipher (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire dsc_pkg::addr_t cfg_addr,
  input  wire dsc_pkg::row_t  cfg_wdata,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dsc_pkg::code_t in_letter_first,
  input  wire dsc_pkg::code_t in_letter_second,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dsc_pkg::code_t      out_cipher_first,
  output dsc_pkg::code_t      out_cipher_second,
  output logic                out_found
);
  import dsc_pkg::*;

  row_t  square_r [SIDE];
  logic  s1_v_r;
  code_t s1_a_r;
  code_t s1_b_r;
  logic  s2_v_r;
  code_t c1_r;
  code_t c2_r;
  logic  found_r;

  code_t c1_nxt;
  code_t c2_nxt;
  logic  found_nxt;
  logic  s2_load;
  logic  s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SIDE; r++) begin
        square_r[r] <= '0;
      end
    end else if (cfg_we && (cfg_addr <= REG_ROW4)) begin
      square_r[cfg_addr[IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // advance the result register when it is empty or being drained
  assign s2_load  = s1_v_r && (!s2_v_r || !out_stall);
  assign in_stall = s1_v_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_a_r <= in_letter_first;
      s1_b_r <= in_letter_second;
    end
  end

  dsc_core u_core (
    .square   (square_r),
    .letter_a (s1_a_r),
    .letter_b (s1_b_r),
    .cipher_a (c1_nxt),
    .cipher_b (c2_nxt),
    .found    (found_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= 1'b1;
    end else if (!out_stall) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      c1_r    <= c1_nxt;
      c2_r    <= c2_nxt;
      found_r <= found_nxt;
    end
  end

  assign out_valid         = s2_v_r;
  assign out_cipher_first  = c1_r;
  assign out_cipher_second = c2_r;
  assign out_found         = found_r;

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid)
    else $error("result register loaded but no valid result");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && !found_nxt) |=>
      (out_cipher_first == $past(s1_a_r) && out_cipher_second == $past(s1_b_r)))
    else $error("unlocated pair did not pass unchanged");

  a_found_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && found_nxt) |=> (out_found && $past(s1_a_r) != $past(s1_b_r)))
    else $error("found set for equal letters");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_v_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// File: sv/dsc_locate.sv
`default_nettype none
module dsc_locate (
  input  dsc_pkg::row_t  square [dsc_pkg::SIDE],
  input  dsc_pkg::code_t code,
  output dsc_pkg::pos_t  pos
);
  import dsc_pkg::*;

  logic [CELLS-1:0] match;
  idx_t             row_idx;
  idx_t             col_idx;

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        match[r*SIDE + c] = (cell_code(square[r], idx_t'(c)) == code);
      end
    end
  end

  // encode by OR-ing indexes of matching cells; valid only when the match is one-hot
  always_comb begin
    row_idx = '0;
    col_idx = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (match[r*SIDE + c]) begin
          row_idx = row_idx | idx_t'(r);
          col_idx = col_idx | idx_t'(c);
        end
      end
    end
  end

  always_comb begin
    pos.hit = (match != '0) && ((match & (match - CELLS'(1))) == '0);
    pos.row = row_idx;
    pos.col = col_idx;
  end

endmodule
`default_nettype wire

// File: sv/dsc_core.sv
`default_nettype none
module dsc_core (
  input  dsc_pkg::row_t  square [dsc_pkg::SIDE],
  input  dsc_pkg::code_t letter_a,
  input  dsc_pkg::code_t letter_b,
  output dsc_pkg::code_t cipher_a,
  output dsc_pkg::code_t cipher_b,
  output logic           found
);
  import dsc_pkg::*;

  pos_t pos_a;
  pos_t pos_b;
  row_t row_a;
  row_t row_b;

  dsc_locate u_loc_a (
    .square (square),
    .code   (letter_a),
    .pos    (pos_a)
  );

  dsc_locate u_loc_b (
    .square (square),
    .code   (letter_b),
    .pos    (pos_b)
  );

  // indexes stay below SIDE whenever the result is used
  always_comb begin
    row_a = '0;
    row_b = '0;
    for (int r = 0; r < SIDE; r++) begin
      if (pos_a.row == idx_t'(r)) begin
        row_a = square[r];
      end
      if (pos_b.row == idx_t'(r)) begin
        row_b = square[r];
      end
    end
  end

  always_comb begin
    found    = (letter_a != letter_b) && pos_a.hit && pos_b.hit;
    cipher_a = letter_a;
    cipher_b = letter_b;
    if (found) begin
      if ((pos_a.row == pos_b.row) || (pos_a.col == pos_b.col)) begin
        cipher_a = letter_b;
        cipher_b = letter_a;
      end else begin
        cipher_a = cell_code(row_a, pos_b.col);
        cipher_b = cell_code(row_b, pos_a.col);
      end
    end
  end

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_SETS  = 10;
  localparam int PAIRS_PER_SET = 122;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    code_t first;
    code_t second;
    logic  found;
  } cipher_t;

  typedef struct packed {
    code_t first;
    code_t second;
  } letter_pair_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
  typedef enum int {SQ_ALPHABET, SQ_WIDE, SQ_REPEATS, SQ_RAW} square_kind_t;

  class cipher_scoreboard;
    row_t    key_rows [SIDE];
    cipher_t expected_ciphers [$];
    int      mismatches;
    int      checked;
    int      enciphered;

    function new();
      foreach (key_rows[r]) key_rows[r] = '0;
      mismatches = 0;
      checked    = 0;
      enciphered = 0;
    endfunction

    function void set_row(int r, row_t value);
      key_rows[r] = value;
    endfunction

    // count the cells holding the code; keep the position of the last one
    function int locate(code_t code, output int row, output int col);
      int hits;
      hits = 0;
      row  = 0;
      col  = 0;
      for (int r = 0; r < SIDE; r++) begin
        for (int k = 0; k < SIDE; k++) begin
          if (key_rows[r][k*CODE_W +: CODE_W] == code) begin
            row = r;
            col = k;
            hits++;
          end
        end
      end
      return hits;
    endfunction

    function cipher_t encipher_pair(code_t p, code_t q);
      cipher_t res;
      int r1, k1, r2, k2, hits1, hits2;
      res.first  = p;
      res.second = q;
      res.found  = 1'b0;
      hits1 = locate(p, r1, k1);
      hits2 = locate(q, r2, k2);
      if (p != q && hits1 == 1 && hits2 == 1) begin
        res.found = 1'b1;
        if (r1 == r2 || k1 == k2) begin
          res.first  = q;
          res.second = p;
        end else begin
          res.first  = key_rows[r1][k2*CODE_W +: CODE_W];
          res.second = key_rows[r2][k1*CODE_W +: CODE_W];
        end
      end
      return res;
    endfunction

    function void note_pair(code_t p, code_t q);
      expected_ciphers.push_back(encipher_pair(p, q));
    endfunction

    function void check_cipher(code_t c1, code_t c2, logic f);
      cipher_t want;
      if (expected_ciphers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cipher %0d %0d found %b", c1, c2, f);
        return;
      end
      want = expected_ciphers.pop_front();
      checked++;
      if (want.found) enciphered++;
      if (c1 !== want.first || c2 !== want.second || f !== want.found) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %0d %0d found %b, got %0d %0d found %b",
                   checked, want.first, want.second, want.found, c1, c2, f);
      end
    endfunction

    function int pending();
      return expected_ciphers.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  addr_t cfg_addr;
  row_t  cfg_wdata;
  logic  in_valid;
  logic  in_stall;
  code_t in_letter_first;
  code_t in_letter_second;
  logic  out_valid;
  logic  out_stall;
  code_t out_cipher_first;
  code_t out_cipher_second;
  logic  out_found;

  cipher_scoreboard sb = new();
  letter_pair_t     pair_queue [$];
  code_t            square_cells [CELLS];
  int               cycles = 0;
  int               square_settings = 0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;

  digraph_square_cipher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_letter_first   (in_letter_first),
    .in_letter_second  (in_letter_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_first  (out_cipher_first),
    .out_cipher_second (out_cipher_second),
    .out_found         (out_found)
  );

  always #5 clk = ~clk;

  // sample both channels on the rising edge
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && !in_stall)
      sb.note_pair(in_letter_first, in_letter_second);
    if (rst_n && out_valid && !out_stall)
      sb.check_cipher(out_cipher_first, out_cipher_second, out_found);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("digraph_square_cipher regression: fail");
      $finish;
    end
  end

  // receiver: stall pattern in stretches, plus one long hold-off on request
  initial begin
    stall_mode_t mode;
    int          span;
    out_stall = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 60);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= k[0];
        endcase
      end
    end
  end

  task automatic write_reg(addr_t addr, row_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    if (addr <= REG_ROW4) sb.set_row(int'(addr), value);
  endtask

  task automatic finish_writes();
    cfg_we <= 1'b0;
    @(negedge clk);
    square_settings++;
  endtask

  task automatic load_square();
    row_t row;
    for (int r = 0; r < SIDE; r++) begin
      row = '0;
      for (int k = 0; k < SIDE; k++) row[k*CODE_W +: CODE_W] = square_cells[r*SIDE + k];
      write_reg(REG_ROW0 + addr_t'(r), row);
    end
    finish_writes();
  endtask

  task automatic build_alphabet(int skipped);
    int n;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != skipped) begin
        square_cells[n] = code_t'(c);
        n++;
      end
    end
  endtask

  task automatic shuffle_cells();
    code_t tmp;
    int    j;
    for (int i = CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = square_cells[i];
      square_cells[i] = square_cells[j];
      square_cells[j] = tmp;
    end
  endtask

  // 25 distinct codes drawn from the full 5-bit range
  task automatic build_wide();
    code_t pool [32];
    code_t tmp;
    int    j;
    for (int i = 0; i < 32; i++) pool[i] = code_t'(i);
    for (int i = 0; i < CELLS; i++) begin
      j = $urandom_range(i, 31);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
      square_cells[i] = pool[i];
    end
  endtask

  task automatic add_pair(int a, int b);
    letter_pair_t lp;
    lp.first  = code_t'(a);
    lp.second = code_t'(b);
    pair_queue.push_back(lp);
  endtask

  function automatic code_t pick_cell();
    int r, k;
    r = $urandom_range(0, SIDE - 1);
    k = $urandom_range(0, SIDE - 1);
    return sb.key_rows[r][k*CODE_W +: CODE_W];
  endfunction

  task automatic queue_random_pairs(int n);
    int    pick;
    code_t a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_pair(pick_cell(), pick_cell());
      end else if (pick < 80) begin
        if (pick[0]) add_pair(pick_cell(), $urandom_range(0, 31));
        else         add_pair($urandom_range(0, 31), pick_cell());
      end else if (pick < 92) begin
        add_pair($urandom_range(0, 31), $urandom_range(0, 31));
      end else begin
        a = pick_cell();
        add_pair(a, a);
      end
    end
  endtask

  // sender: bursts of transfers with random gaps, then wait for the results
  task automatic send_pairs();
    int burst, gap, n;
    n = 0;
    while (n < pair_queue.size()) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && n < pair_queue.size(); k++) begin
        in_valid         <= 1'b1;
        in_letter_first  <= pair_queue[n].first;
        in_letter_second <= pair_queue[n].second;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    pair_queue.delete();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    square_kind_t kind;
    int           leftover;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_letter_first  = '0;
    in_letter_second = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset square: every cell holds code 0
    add_pair(0, 0);
    add_pair(0, 1);
    add_pair(31, 0);
    add_pair(5, 6);
    send_pairs();

    // classic square without j
    build_alphabet(9);
    load_square();
    add_pair(0, 25);
    add_pair(25, 0);
    add_pair(0, 4);
    add_pair(0, 21);
    add_pair(12, 18);
    add_pair(8, 10);
    add_pair(7, 7);
    add_pair(9, 3);
    add_pair(3, 9);
    add_pair(26, 3);
    add_pair(31, 31);
    add_pair(0, 0);
    add_pair(25, 25);
    send_pairs();

    // indexes past the last row must leave the square alone
    for (int a = int'(REG_ROW4) + 1; a < (1 << ADDR_W); a++)
      write_reg(addr_t'(a), row_t'($urandom));
    finish_writes();
    add_pair(0, 25);
    add_pair(14, 16);
    send_pairs();

    // letter d in two cells, n dropped
    build_alphabet(9);
    square_cells[12] = code_t'(3);
    load_square();
    add_pair(3, 5);
    add_pair(13, 0);
    add_pair(0, 24);
    send_pairs();

    // every cell holds code 31
    for (int r = 0; r < SIDE; r++) write_reg(REG_ROW0 + addr_t'(r), '1);
    finish_writes();
    add_pair(31, 0);
    add_pair(0, 31);
    add_pair(31, 31);
    send_pairs();

    for (int s = 0; s < RANDOM_SETS; s++) begin
      kind = square_kind_t'(s % 4);
      case (kind)
        SQ_ALPHABET: begin
          build_alphabet($urandom_range(0, 25));
          shuffle_cells();
          load_square();
        end
        SQ_WIDE: begin
          build_wide();
          load_square();
        end
        SQ_REPEATS: begin
          build_wide();
          repeat ($urandom_range(1, 3))
            square_cells[$urandom_range(0, CELLS - 1)] = square_cells[$urandom_range(0, CELLS - 1)];
          load_square();
        end
        default: begin
          for (int r = 0; r < SIDE; r++) write_reg(REG_ROW0 + addr_t'(r), row_t'($urandom));
          finish_writes();
        end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (s == 0) hold_req = 1'b1;
      queue_random_pairs(PAIRS_PER_SET);
      send_pairs();
    end

    repeat (8) @(negedge clk);
    leftover = sb.pending();
    if (leftover != 0) begin
      sb.mismatches += leftover;
      $display("%0d expected results never arrived", leftover);
    end
    $display("checked %0d letter pairs over %0d square settings", sb.checked, square_settings);
    $display("%0d pairs enciphered, %0d passed through unchanged",
             sb.enciphered, sb.checked - sb.enciphered);
    if (sb.mismatches == 0) begin
      $display("digraph_square_cipher regression: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("digraph_square_cipher regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
